// ----- rtl/tccs_pkg.sv -----
package tccs_pkg;

    // Grid geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 24;
    localparam int CELLS   = ROWS * COLUMNS;

    // Cursor column reaches COLUMNS itself (pending wrap)
    localparam int COL_W  = $clog2(COLUMNS + 1);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'd32;
    localparam logic [7:0] BLANK_CODE   = 8'd0;

    localparam logic [1:0] MODE_PUT   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] char_in;
        logic [6:0] read_col;
        logic [4:0] read_row;
    } req_t;

    typedef struct packed {
        logic [7:0] read_char;
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic       scrolled;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_PUT,
        ST_CLEAR,
        ST_READ,
        ST_FLUSH
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic cursor_home;
        logic wrap_line;
        logic scroll_start;
        logic clear_start;
        logic sweep_step;
        logic put_write;
        logic read_issue;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       wrap_needed;
        logic       at_last_row;
        logic       is_newline;
        logic       sweep_last;
        logic       out_free;
    } dp_status_t;

    // Screen row to physical row; both operands are below ROWS
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
                                                  input logic [ROW_W-1:0] row);
        logic [ROW_W:0] sum;
        sum = {1'b0, top} + {1'b0, row};
        if (sum >= (ROW_W + 1)'(ROWS)) begin
            sum = sum - (ROW_W + 1)'(ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

endpackage

// ----- rtl/text_console_cursor_scroll.sv -----
// Sequence: a put is captured, executed and loaded into the result register; a read
// reads the cell before its result is loaded; a put that scrolls first blanks one row,
// and a clear first refills every cell. The cell memory has a single write port, and
// the controller takes one transaction at a time: req_stall stays high until the result
// is loaded, also while a stalled output holds it. Reset: cursor and scroll offset go
// to zero, then a clearing pass writes spaces to every cell while req_stall stays high.
module text_console_cursor_scroll
    import tccs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    // Command and status between the sequencer and the grid datapath
    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer: decodes the captured transaction, runs scroll and clear
    // sweeps, and holds the result until the output register is free.
    tccs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: cell memory, cursor, top-row offset and the result register.
    // Scrolling advances the top-row offset and blanks one physical row,
    // so no cells move.
    tccs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// ----- rtl/tccs_ctrl.sv -----
module tccs_ctrl
    import tccs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            ST_INIT: begin
                // fill the grid with spaces after reset
                cmd.sweep_step = 1'b1;
                if (status.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                req_stall = 1'b0;
                if (req_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (status.mode)
                    MODE_PUT: begin
                        if (status.wrap_needed && status.at_last_row) begin
                            cmd.scroll_start = 1'b1;
                            state_next       = ST_SCROLL;
                        end else begin
                            cmd.wrap_line = status.wrap_needed;
                            cmd.put_write = !status.is_newline;
                            cmd.out_load  = status.out_free;
                            state_next    = status.out_free ? ST_IDLE : ST_FLUSH;
                        end
                    end
                    MODE_CLEAR: begin
                        cmd.cursor_home = 1'b1;
                        cmd.clear_start = 1'b1;
                        state_next      = ST_CLEAR;
                    end
                    MODE_READ: begin
                        cmd.read_issue = 1'b1;
                        state_next     = ST_READ;
                    end
                    default: begin
                        cmd.out_load = status.out_free;
                        state_next   = status.out_free ? ST_IDLE : ST_FLUSH;
                    end
                endcase
            end
            ST_SCROLL: begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last) begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT: begin
                cmd.put_write = !status.is_newline;
                cmd.out_load  = status.out_free;
                state_next    = status.out_free ? ST_IDLE : ST_FLUSH;
            end
            ST_CLEAR: begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_READ: begin
                cmd.out_load = status.out_free;
                state_next   = status.out_free ? ST_IDLE : ST_FLUSH;
            end
            ST_FLUSH: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/tccs_dp.sv -----
module tccs_dp
    import tccs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  req_t       req,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output rsp_t       rsp
);

    logic [7:0] mem [CELLS];

    req_t              req_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  line_reg;
    logic [ROW_W-1:0]  top_reg;
    logic              scrolled_reg;
    logic              rd_ok_reg;
    logic [7:0]        rd_data_reg;
    logic [ADDR_W-1:0] sweep_addr_reg;
    logic [ADDR_W-1:0] sweep_end_reg;
    logic [7:0]        fill_reg;
    rsp_t              rsp_reg;
    logic              rsp_valid_reg;

    logic [COL_W-1:0]  col_eff;
    logic [ROW_W-1:0]  line_eff;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  top_next;
    logic [ADDR_W-1:0] put_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_ok;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;

    // Cursor after an optional line wrap, and after an optional store
    assign col_eff  = cmd.wrap_line ? '0 : col_reg;
    assign line_eff = cmd.wrap_line ? line_reg + 1'b1 : line_reg;
    assign col_next = cmd.put_write ? col_eff + 1'b1 : col_eff;
    assign top_next = (top_reg == ROW_W'(ROWS - 1)) ? '0 : top_reg + 1'b1;
    assign put_addr = cell_addr(phys_row(top_reg, line_eff), col_eff);

    assign rd_ok   = (int'(req_reg.read_col) < COLUMNS) && (int'(req_reg.read_row) < ROWS);
    assign rd_addr = cell_addr(phys_row(top_reg, ROW_W'(req_reg.read_row)),
                               COL_W'(req_reg.read_col));

    assign we    = cmd.sweep_step || cmd.put_write;
    assign waddr = cmd.sweep_step ? sweep_addr_reg : put_addr;
    assign wdata = cmd.sweep_step ? fill_reg : req_reg.char_in;

    assign status.mode        = req_reg.mode;
    assign status.wrap_needed = (col_reg >= COL_W'(COLUMNS)) || (req_reg.char_in == NEWLINE_CODE);
    assign status.at_last_row = (line_reg == ROW_W'(ROWS - 1));
    assign status.is_newline  = (req_reg.char_in == NEWLINE_CODE);
    assign status.sweep_last  = (sweep_addr_reg == sweep_end_reg);
    assign status.out_free    = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.read_issue && rd_ok) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.capture) begin
            req_reg <= req;
        end
        if (cmd.read_issue) begin
            rd_ok_reg <= rd_ok;
        end
        if (cmd.out_load) begin
            rsp_reg.read_char  <= (req_reg.mode == MODE_READ && rd_ok_reg) ?
                                  rd_data_reg : BLANK_CODE;
            rsp_reg.cursor_col <= 7'(col_next);
            rsp_reg.cursor_row <= 5'(line_eff);
            rsp_reg.scrolled   <= scrolled_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            col_reg        <= '0;
            line_reg       <= '0;
            top_reg        <= '0;
            scrolled_reg   <= 1'b0;
            sweep_addr_reg <= '0;
            sweep_end_reg  <= ADDR_W'(CELLS - 1);
            fill_reg       <= SPACE_CODE;
            rsp_valid_reg  <= 1'b0;
        end else begin
            if (cmd.capture) begin
                scrolled_reg <= 1'b0;
            end
            if (cmd.cursor_home) begin
                col_reg  <= '0;
                line_reg <= '0;
                top_reg  <= '0;
            end else if (cmd.scroll_start) begin
                // drop the old top row: it becomes the new bottom row
                col_reg        <= '0;
                top_reg        <= top_next;
                scrolled_reg   <= 1'b1;
                sweep_addr_reg <= cell_addr(top_reg, '0);
                sweep_end_reg  <= cell_addr(top_reg, COL_W'(COLUMNS - 1));
                fill_reg       <= BLANK_CODE;
            end else begin
                col_reg  <= col_next;
                line_reg <= line_eff;
            end
            if (cmd.clear_start) begin
                sweep_addr_reg <= '0;
                sweep_end_reg  <= ADDR_W'(CELLS - 1);
                fill_reg       <= SPACE_CODE;
            end else if (cmd.sweep_step) begin
                sweep_addr_reg <= sweep_addr_reg + 1'b1;
            end
            if (cmd.out_load) begin
                rsp_valid_reg <= 1'b1;
            end else if (!rsp_stall) begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- sim/testbench.sv -----
module testbench
    import tccs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 20;
    localparam int PHASE_ITEMS = 100;      // counted random transactions per phase
    localparam int CYCLE_LIMIT = 500_000;  // far beyond the slowest run with clears
    localparam int DRAIN_TAIL  = 100;      // quiet cycles after the last result

    // Mode 3 does nothing in the block; give it a name for the stimulus
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    text_console_cursor_scroll dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Free-running clock
    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Console shadow: grid, cursor and scroll offset kept in step with
    // every request transaction the block accepts
    // ------------------------------------------------------------------
    logic [7:0] shadow_cells [ROWS][COLUMNS];
    int         shadow_col;
    int         shadow_row;
    int         shadow_top;   // physical row that shows as screen row 0

    req_t pending_ops [$];    // requests not yet driven
    rsp_t console_expected [$];
    rsp_t predicted_rsp;

    int idle_pct  = 0;        // sender idle chance, percent per free cycle
    int stall_pct = 0;        // receiver stall chance, percent per cycle

    int mismatch_count = 0;
    int cycle_count    = 0;
    int checked_count  = 0;
    int stim_count     = 0;
    int put_count      = 0;
    int read_count     = 0;
    int clear_count    = 0;
    int unused_count   = 0;
    int scroll_count   = 0;
    int wrap_count     = 0;

    task automatic clear_shadow();
        foreach (shadow_cells[r, c]) begin
            shadow_cells[r][c] = SPACE_CODE;
        end
        shadow_col = 0;
        shadow_row = 0;
        shadow_top = 0;
    endtask

    // Apply one accepted request to the shadow and form the expected result
    task automatic apply_console_op(input req_t op, output rsp_t result);
        logic [7:0] read_value;
        logic       did_scroll;
        read_value = BLANK_CODE;
        did_scroll = 1'b0;
        case (op.mode)
            MODE_PUT: begin
                put_count++;
                if (shadow_col >= COLUMNS || op.char_in == NEWLINE_CODE) begin
                    if (op.char_in != NEWLINE_CODE) begin
                        wrap_count++;
                    end
                    shadow_row++;
                    shadow_col = 0;
                    if (shadow_row >= ROWS) begin
                        // old top row becomes the new, zero-filled bottom row
                        for (int c = 0; c < COLUMNS; c++) begin
                            shadow_cells[shadow_top][c] = BLANK_CODE;
                        end
                        shadow_top = (shadow_top + 1) % ROWS;
                        shadow_row = ROWS - 1;
                        did_scroll = 1'b1;
                        scroll_count++;
                    end
                end
                if (op.char_in != NEWLINE_CODE) begin
                    shadow_cells[(shadow_top + shadow_row) % ROWS][shadow_col] = op.char_in;
                    shadow_col++;
                end
            end
            MODE_CLEAR: begin
                clear_count++;
                clear_shadow();
            end
            MODE_READ: begin
                read_count++;
                if (op.read_col < COLUMNS && op.read_row < ROWS) begin
                    read_value =
                        shadow_cells[(shadow_top + int'(op.read_row)) % ROWS][op.read_col];
                end
            end
            default: begin
                unused_count++;
            end
        endcase
        result.read_char  = read_value;
        result.cursor_col = 7'(shadow_col);
        result.cursor_row = 5'(shadow_row);
        result.scrolled   = did_scroll;
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_console_rsp(input rsp_t got);
        rsp_t want;
        if (console_expected.size() == 0) begin
            report_mismatch($sformatf("unexpected result %p", got));
        end
        else begin
            want = console_expected.pop_front();
            checked_count++;
            if (got.read_char !== want.read_char) begin
                report_mismatch($sformatf("read_char got %0d want %0d",
                                          got.read_char, want.read_char));
            end
            if (got.cursor_col !== want.cursor_col) begin
                report_mismatch($sformatf("cursor_col got %0d want %0d",
                                          got.cursor_col, want.cursor_col));
            end
            if (got.cursor_row !== want.cursor_row) begin
                report_mismatch($sformatf("cursor_row got %0d want %0d",
                                          got.cursor_row, want.cursor_row));
            end
            if (got.scrolled !== want.scrolled) begin
                report_mismatch($sformatf("scrolled got %0b want %0b",
                                          got.scrolled, want.scrolled));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: predict on every accepted request transaction, then either
    // hold a stalled payload or present the next pending one
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else begin
            if (req_valid && !req_stall) begin
                apply_console_op(req, predicted_rsp);
                console_expected.push_back(predicted_rsp);
            end
            // hold while stalled; otherwise advance or go idle
            if (!req_valid || !req_stall) begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    req_valid <= 1'b1;
                    req       <= pending_ops.pop_front();
                end
                else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each accepted result transaction, stall at random
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rsp_stall <= 1'b0;
        end
        else begin
            if (rsp_valid && !rsp_stall) begin
                check_console_rsp(rsp);
            end
            rsp_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, console_expected.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic req_t make_op(input logic [1:0] mode, input logic [7:0] ch,
                                     input logic [6:0] col, input logic [4:0] row);
        req_t op;
        op.mode     = mode;
        op.char_in  = ch;
        op.read_col = col;
        op.read_row = row;
        return op;
    endfunction

    // Any byte except newline
    function automatic logic [7:0] text_char();
        logic [7:0] ch;
        ch = 8'($urandom_range(255));
        if (ch == NEWLINE_CODE) begin
            ch = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
        end
        return ch;
    endfunction

    function automatic logic [7:0] put_char_mix();
        return ($urandom_range(99) < 20) ? NEWLINE_CODE : text_char();
    endfunction

    task automatic queue_op(input req_t op);
        pending_ops.push_back(op);
        if (op.mode != MODE_UNUSED) begin
            stim_count++;
        end
    endtask

    task automatic queue_put(input logic [7:0] ch);
        // fields that the put ignores still get random values
        queue_op(make_op(MODE_PUT, ch, 7'($urandom), 5'($urandom)));
    endtask

    task automatic queue_read(input int col, input int row);
        queue_op(make_op(MODE_READ, 8'($urandom), 7'(col), 5'(row)));
    endtask

    // Mostly cells on screen, bottom rows favored; some anywhere in the fields
    task automatic queue_random_read();
        if ($urandom_range(99) < 15) begin
            queue_read($urandom_range(127), $urandom_range(31));
        end
        else if ($urandom_range(1) != 0) begin
            queue_read($urandom_range(COLUMNS - 1), $urandom_range(ROWS - 1, ROWS - 6));
        end
        else begin
            queue_read($urandom_range(COLUMNS - 1), $urandom_range(ROWS - 1));
        end
    endtask

    task automatic queue_directed();
        // fresh screen is all spaces; probe corners and out-of-range cells
        queue_read(0, 0);
        queue_read(COLUMNS - 1, ROWS - 1);
        queue_read(COLUMNS, 0);
        queue_read(127, 31);
        queue_read(0, ROWS);
        // extreme bytes, then read them back
        queue_put(8'h00);
        queue_put(8'hFF);
        queue_put(8'h41);
        queue_put(SPACE_CODE);
        for (int c = 0; c < 4; c++) begin
            queue_read(c, 0);
        end
        // empty line, then the unused mode with every field at its top
        queue_put(NEWLINE_CODE);
        queue_put(NEWLINE_CODE);
        queue_op(make_op(MODE_UNUSED, 8'hFF, 7'h7F, 5'h1F));
        queue_read(0, 1);
        queue_put(8'h5A);
        queue_read(0, 2);
        // clear homes the cursor and refills spaces
        queue_op(make_op(MODE_CLEAR, 8'hFF, 7'h7F, 5'h1F));
        queue_read(0, 0);
        queue_read(0, 2);
        queue_put(8'h7F);
    endtask

    task automatic queue_random_segment();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 40) begin
            // short mix of everything
            n = $urandom_range(1, 8);
            repeat (n) begin
                pick = $urandom_range(99);
                if (pick < 65) begin
                    queue_put(put_char_mix());
                end
                else if (pick < 88) begin
                    queue_random_read();
                end
                else begin
                    queue_op(make_op(MODE_UNUSED, 8'($urandom), 7'($urandom),
                                     5'($urandom)));
                end
            end
        end
        else if (pick < 48) begin
            // fill a whole line into pending wrap, peek, then wrap or break
            queue_put(NEWLINE_CODE);
            repeat (COLUMNS) begin
                queue_put(text_char());
            end
            queue_random_read();
            queue_put(($urandom_range(1) != 0) ? NEWLINE_CODE : text_char());
        end
        else if (pick < 72) begin
            // run of mostly newlines moves the cursor toward the bottom and may scroll
            n = $urandom_range(4, 24);
            repeat (n) begin
                queue_put(($urandom_range(99) < 80) ? NEWLINE_CODE : text_char());
            end
        end
        else if (pick < 95) begin
            n = $urandom_range(2, 6);
            repeat (n) begin
                queue_random_read();
            end
        end
        else begin
            queue_op(make_op(MODE_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom)));
        end
    endtask

    // Wait at the falling edge so driver pops and valid updates have settled
    task automatic wait_drained();
        while (pending_ops.size() != 0 || req_valid || console_expected.size() != 0) begin
            @(negedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset, four phases with different idle and stall chances, drain, verdict
    // ------------------------------------------------------------------
    initial begin
        int phase_start;
        clear_shadow();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 70; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 70; end
                default: begin idle_pct = 32; stall_pct = 32; end
            endcase
            if (phase == 0) begin
                queue_directed();
            end
            phase_start = stim_count;
            while (stim_count - phase_start < PHASE_ITEMS) begin
                queue_random_segment();
            end
            wait_drained();
        end

        // nothing more may arrive once every expectation is met
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("covered %0d transactions in %0d cycles: %0d puts, %0d reads, %0d clears,",
                 stim_count, cycle_count, put_count, read_count, clear_count);
        $display("  %0d ignored ops, %0d line wraps, %0d scrolls, %0d results checked",
                 unused_count, wrap_count, scroll_count, checked_count);
        if (mismatch_count == 0 && console_expected.size() == 0) begin
            $display("tb: success");
        end
        else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
